### design/bbpc_pkg.sv
`default_nettype none
package bbpc_pkg;

  localparam int NUM_CLASSES = 10;
  localparam int IMAGE_SIDE  = 28;
  localparam int LOG_WIDTH   = 16;

  localparam int PIXELS  = IMAGE_SIDE * IMAGE_SIDE;
  localparam int PIX_AW  = $clog2(PIXELS);
  localparam int CLS_W   = 4;
  localparam int PIX_W   = 10;
  localparam int IN_LOG_W = 16;
  localparam int SCORE_W = 32;

  localparam int IN_TDATA_W  = 48;
  localparam int OUT_TDATA_W = 40;
  localparam int CMD_W       = 2;

  localparam logic signed [SCORE_W-1:0] FLOOR_RESET = -32'sd5120000;

  localparam int TREE_LVLS = $clog2(NUM_CLASSES + 1);
  localparam int TREE_N    = 1 << TREE_LVLS;

  localparam int FIFO_DEPTH = 8;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

  localparam int RESULT_LATENCY = 2 + TREE_LVLS;

  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD_TERMS = 2'd0,
    CMD_LOAD_PRIOR = 2'd1,
    CMD_CLASSIFY   = 2'd2
  } cmd_t;

  typedef logic signed [LOG_WIDTH-1:0] log_t;
  typedef logic signed [SCORE_W-1:0]   score_t;

  typedef struct packed {
    log_t shaded;
    log_t blank;
  } terms_t;

  typedef struct packed {
    logic             valid;
    logic [CLS_W-1:0] cls;
    score_t           score;
  } cand_t;

endpackage
`default_nettype wire

### design/bernoulli_bayes_pixel_classifier.sv
// Takes one beat per cycle on every command while s_tready is high; loads and pixels
// may follow back to back. A result reaches the master side after the last pixel beat
// passes the banked term memories, the accumulators, each level of the registered
// comparison tree and the result FIFO. The slave side stalls only while eight results
// are owed to the master side. Reset clears control state and sets the floor to
// FLOOR_RESET; term memories and priors are undefined until loaded.
`default_nettype none
module bernoulli_bayes_pixel_classifier import bbpc_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  // class_index[3:0], pixel_index[13:4], log_if_shaded[29:14], log_if_blank[45:30],
  // pixel_blank[46], zero[47]
  input  logic [IN_TDATA_W-1:0]  s_tdata,
  // command[1:0]
  input  logic [CMD_W-1:0]       s_tuser,
  input  logic                   s_tlast,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  // winning_class[3:0], best_score[35:4], zero[39:36]
  output logic [OUT_TDATA_W-1:0] m_tdata,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [SCORE_W-1:0]     cfg_data
);

  function automatic score_t sat_add(score_t s, log_t t);
    logic signed [SCORE_W:0] sum;
    sum = $signed({s[SCORE_W-1], s}) + (SCORE_W+1)'(t);
    if (sum[SCORE_W] != sum[SCORE_W-1]) begin
      return sum[SCORE_W] ? {1'b1, {(SCORE_W-1){1'b0}}} : {1'b0, {(SCORE_W-1){1'b1}}};
    end
    return sum[SCORE_W-1:0];
  endfunction

  logic [CLS_W-1:0]           class_index;
  logic [PIX_W-1:0]           pixel_index;
  logic signed [IN_LOG_W-1:0] log_if_shaded;
  logic signed [IN_LOG_W-1:0] log_if_blank;
  logic                       pixel_blank;
  cmd_t                       cmd;

  assign class_index   = s_tdata[3:0];
  assign pixel_index   = s_tdata[13:4];
  assign log_if_shaded = s_tdata[29:14];
  assign log_if_blank  = s_tdata[45:30];
  assign pixel_blank   = s_tdata[46];
  assign cmd           = cmd_t'(s_tuser);

  logic accept, load_terms, load_prior, classify, pix_ok;
  logic [PIX_AW-1:0] pix_addr;
  log_t   shaded_st, blank_st;
  terms_t wr_terms;

  assign accept     = s_tvalid && s_tready;
  assign load_terms = accept && (cmd == CMD_LOAD_TERMS);
  assign load_prior = accept && (cmd == CMD_LOAD_PRIOR);
  assign classify   = accept && (cmd == CMD_CLASSIFY);
  assign pix_ok     = int'(pixel_index) < PIXELS;
  assign pix_addr   = PIX_AW'(pixel_index);
  assign shaded_st  = LOG_WIDTH'(log_if_shaded);
  assign blank_st   = LOG_WIDTH'(log_if_blank);
  assign wr_terms   = '{shaded: shaded_st, blank: blank_st};

  score_t score_floor;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      score_floor <= FLOOR_RESET;
    end else if (cfg_valid && cfg_ready) begin
      score_floor <= cfg_data;
    end
  end

  logic in_progress;
  logic s1_valid, s1_first, s1_add, s1_blank, s1_last, fin;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_progress <= 1'b0;
      s1_valid    <= 1'b0;
      fin         <= 1'b0;
    end else begin
      if (classify) begin
        in_progress <= !s_tlast;
      end
      s1_valid <= classify;
      fin      <= s1_valid && s1_last;
    end
  end

  always_ff @(posedge clk) begin
    s1_first <= !in_progress;
    s1_add   <= pix_ok;
    s1_blank <= pixel_blank;
    s1_last  <= s_tlast;
  end

  log_t   prior      [NUM_CLASSES];
  score_t score      [NUM_CLASSES];
  score_t score_next [NUM_CLASSES];

  for (genvar c = 0; c < NUM_CLASSES; c++) begin : g_class
    terms_t rd;
    score_t base;
    log_t   term;

    bbpc_ram #(
      .WIDTH ($bits(terms_t)),
      .DEPTH (PIXELS)
    ) u_ram (
      .clk     (clk),
      .wr_en   (load_terms && pix_ok && (class_index == CLS_W'(c))),
      .wr_addr (pix_addr),
      .wr_data (wr_terms),
      .rd_en   (classify),
      .rd_addr (pix_addr),
      .rd_data (rd)
    );

    always_comb begin
      base          = s1_first ? score_t'(prior[c]) : score[c];
      term          = s1_add ? (s1_blank ? rd.blank : rd.shaded) : '0;
      score_next[c] = sat_add(base, term);
    end

    always_ff @(posedge clk) begin
      if (load_prior && (class_index == CLS_W'(c))) begin
        prior[c] <= blank_st;
      end
      if (s1_valid) begin
        score[c] <= score_next[c];
      end
    end
  end

  logic  res_valid;
  cand_t res;

  bbpc_argmax u_argmax (
    .clk    (clk),
    .rst    (rst),
    .start  (fin),
    .floor  (score_floor),
    .scores (score),
    .done   (res_valid),
    .best   (res)
  );

  logic [OUT_TDATA_W-1:0] fifo [FIFO_DEPTH];
  logic [FIFO_AW-1:0]     wr_ptr, rd_ptr;
  logic [CNT_W-1:0]       count, pending;
  logic                   pop, owe;

  assign pop      = m_tvalid && m_tready;
  assign owe      = classify && s_tlast;
  assign m_tvalid = count != '0;
  assign m_tdata  = fifo[rd_ptr];
  assign s_tready = pending < CNT_W'(FIFO_DEPTH);

  always_ff @(posedge clk) begin
    if (res_valid) begin
      fifo[wr_ptr] <= OUT_TDATA_W'({res.score, res.cls});
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr  <= '0;
      rd_ptr  <= '0;
      count   <= '0;
      pending <= '0;
    end else begin
      if (res_valid) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({res_valid, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
      case ({owe, pop})
        2'b10:   pending <= pending + 1'b1;
        2'b01:   pending <= pending - 1'b1;
        default: pending <= pending;
      endcase
    end
  end

endmodule
`default_nettype wire

### design/bbpc_ram.sv
`default_nettype none
module bbpc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

### design/bbpc_argmax.sv
`default_nettype none
module bbpc_argmax import bbpc_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   start,
  input  score_t floor,
  input  score_t scores [NUM_CLASSES],
  output logic   done,
  output cand_t  best
);

  function automatic cand_t pick(cand_t a, cand_t b);
    if (b.valid && (!a.valid || ($signed(b.score) > $signed(a.score)))) begin
      return b;
    end
    return a;
  endfunction

  cand_t                leaf [TREE_N];
  cand_t                lvl  [TREE_LVLS][TREE_N/2];
  logic [TREE_LVLS-1:0] vld;

  // The floor sits left of class 0 so that a class must beat it strictly.
  always_comb begin
    for (int i = 0; i < TREE_N; i++) begin
      leaf[i] = '0;
    end
    leaf[0] = '{valid: 1'b1, cls: '0, score: floor};
    for (int c = 0; c < NUM_CLASSES; c++) begin
      leaf[c + 1] = '{valid: 1'b1, cls: CLS_W'(c), score: scores[c]};
    end
  end

  for (genvar i = 0; i < TREE_N / 2; i++) begin : g_leaf
    always_ff @(posedge clk) begin
      lvl[0][i] <= pick(leaf[2*i], leaf[2*i + 1]);
    end
  end

  for (genvar k = 1; k < TREE_LVLS; k++) begin : g_lvl
    for (genvar i = 0; i < (TREE_N >> (k + 1)); i++) begin : g_node
      always_ff @(posedge clk) begin
        lvl[k][i] <= pick(lvl[k-1][2*i], lvl[k-1][2*i + 1]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[TREE_LVLS-2:0], start};
    end
  end

  assign done = vld[TREE_LVLS-1];
  assign best = lvl[TREE_LVLS-1][0];

endmodule
`default_nettype wire

### design/bbpc_checker.sv
`default_nettype none
module bbpc_checker import bbpc_pkg::*; (
  input wire logic                   clk,
  input wire logic                   rst,
  input wire logic                   s_tvalid,
  input wire logic                   s_tready,
  input wire logic [IN_TDATA_W-1:0]  s_tdata,
  input wire logic [CMD_W-1:0]       s_tuser,
  input wire logic                   s_tlast,
  input wire logic                   m_tvalid,
  input wire logic                   m_tready,
  input wire logic [OUT_TDATA_W-1:0] m_tdata,
  input wire logic                   cfg_valid,
  input wire logic                   cfg_ready,
  input wire logic [SCORE_W-1:0]     cfg_data
);

  logic last_beat;
  assign last_beat = s_tvalid && s_tready && s_tlast && (s_tuser == CMD_CLASSIFY);

  a_reset_clears: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("Result beat present right after reset.");

  a_result_latency: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(last_beat, RESULT_LATENCY + 1))
    else $error("Result beat appeared without a last pixel beat at the fixed latency.");

  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("Stalled result beat changed or dropped.");

  a_class_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> int'(m_tdata[3:0]) < NUM_CLASSES)
    else $error("Result class out of range.");

endmodule

bind bernoulli_bayes_pixel_classifier bbpc_checker u_bbpc_checker (.*);
`default_nettype wire

### tb/testbench.sv
`default_nettype none
module testbench;
  import bbpc_pkg::*;

  localparam int TABLE_DEPTH = NUM_CLASSES * PIXELS;
  localparam int IDLE_LIMIT = 4000;
  localparam int PHASE_ITEMS = 180;
  localparam int MIN_RESULTS = 48;
  localparam int NUM_PHASES = 6;
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  typedef logic signed [IN_LOG_W-1:0] in_log_t;

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic [CLS_W-1:0] cls;
    logic [PIX_W-1:0] pix;
    in_log_t          shaded;
    in_log_t          blank_log;
    logic             is_blank;
    logic             last;
  } beat_t;

  typedef struct packed {
    logic [CLS_W-1:0] cls;
    score_t           score;
  } winner_t;

  typedef struct packed {
    beat_t   b;
    logic    typed;
    winner_t res;
  } step_t;

  logic                   clk = 1'b0;
  logic                   rst;
  logic                   s_tvalid;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata;
  logic [CMD_W-1:0]       s_tuser;
  logic                   s_tlast;
  logic                   m_tvalid;
  logic                   m_tready;
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [SCORE_W-1:0]     cfg_data;

  always #10 clk = ~clk;

  bernoulli_bayes_pixel_classifier u_top (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  log_t    shaded_mem [TABLE_DEPTH];
  log_t    blank_mem  [TABLE_DEPTH];
  log_t    prior_mem  [NUM_CLASSES];
  score_t  acc        [NUM_CLASSES];
  bit      term_written [TABLE_DEPTH];
  bit      pixel_ready  [PIXELS];
  int      ready_pixels [$];
  bit      mid_image = 1'b0;
  score_t  floor_val = FLOOR_RESET;

  winner_t pending_winners [$];
  step_t   plan [$];
  winner_t no_result = '0;
  int      fault_count = 0;
  int      result_count = 0;
  int      work_items = 0;
  bit      tx_idle = 1'b1;
  bit      rx_stalls = 1'b1;
  int      rx_hold = 0;
  int      idle_cycles = 0;

  // Returns 1 when the beat completes an image, with the winning class and score.
  function automatic bit score_beat(input beat_t b, output winner_t w);
    int     addr;
    longint sum;
    log_t   term;
    bit     all_loaded;
    w.cls = '0;
    w.score = floor_val;
    if (b.cmd == CMD_LOAD_TERMS) begin
      if (b.cls < NUM_CLASSES && b.pix < PIXELS) begin
        addr = b.cls * PIXELS + b.pix;
        shaded_mem[addr] = log_t'(b.shaded);
        blank_mem[addr] = log_t'(b.blank_log);
        term_written[addr] = 1'b1;
        if (!pixel_ready[b.pix]) begin
          all_loaded = 1'b1;
          for (int c = 0; c < NUM_CLASSES; c++)
            all_loaded &= term_written[c * PIXELS + b.pix];
          if (all_loaded) begin
            pixel_ready[b.pix] = 1'b1;
            ready_pixels.insert(ready_pixels.size(), b.pix);
          end
        end
      end
      return 1'b0;
    end
    if (b.cmd == CMD_LOAD_PRIOR) begin
      if (b.cls < NUM_CLASSES)
        prior_mem[b.cls] = log_t'(b.blank_log);
      return 1'b0;
    end
    if (b.cmd != CMD_CLASSIFY)
      return 1'b0;
    if (!mid_image) begin
      for (int c = 0; c < NUM_CLASSES; c++)
        acc[c] = prior_mem[c];
      mid_image = 1'b1;
    end
    if (b.pix < PIXELS) begin
      for (int c = 0; c < NUM_CLASSES; c++) begin
        addr = c * PIXELS + b.pix;
        term = b.is_blank ? blank_mem[addr] : shaded_mem[addr];
        sum = longint'(acc[c]) + longint'(term);
        if (sum > longint'(32'sh7fffffff))
          acc[c] = 32'sh7fffffff;
        else if (sum < -longint'(64'sh80000000))
          acc[c] = 32'sh80000000;
        else
          acc[c] = score_t'(sum);
      end
    end
    if (!b.last)
      return 1'b0;
    for (int c = 0; c < NUM_CLASSES; c++) begin
      if (acc[c] > w.score) begin
        w.score = acc[c];
        w.cls = c[CLS_W-1:0];
      end
    end
    mid_image = 1'b0;
    return 1'b1;
  endfunction

  function automatic beat_t mk(input logic [CMD_W-1:0] cmd, input int cls, input int pix,
                               input in_log_t shaded, input in_log_t blank_log,
                               input bit is_blank, input bit last);
    beat_t b;
    b.cmd = cmd;
    b.cls = cls[CLS_W-1:0];
    b.pix = pix[PIX_W-1:0];
    b.shaded = shaded;
    b.blank_log = blank_log;
    b.is_blank = is_blank;
    b.last = last;
    return b;
  endfunction

  function automatic in_log_t rand_log();
    int r;
    int v;
    r = $urandom_range(0, 9);
    if (r == 0)
      return '0;
    if (r == 1)
      return in_log_t'(-32768);
    v = $urandom_range(0, 32768);
    return in_log_t'(-v);
  endfunction

  function automatic int sender_gap();
    int r;
    if (!tx_idle)
      return 0;
    r = $urandom_range(0, 99);
    if (r < 60)
      return 0;
    if (r < 92)
      return $urandom_range(1, 3);
    return $urandom_range(4, 24);
  endfunction

  task automatic send_step(input beat_t b, input bit typed, input winner_t typed_res);
    int      gap;
    winner_t w;
    gap = sender_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {1'b0, b.is_blank, b.blank_log, b.shaded, b.pix, b.cls};
    s_tuser <= b.cmd;
    s_tlast <= b.last;
    do @(posedge clk); while (!s_tready);
    if ((b.cmd == CMD_CLASSIFY) || (b.cmd == CMD_LOAD_PRIOR && b.cls < NUM_CLASSES) ||
        (b.cmd == CMD_LOAD_TERMS && b.cls < NUM_CLASSES && b.pix < PIXELS))
      work_items++;
    if (score_beat(b, w)) begin
      pending_winners.insert(pending_winners.size(), typed ? typed_res : w);
      result_count++;
    end
  endtask

  task automatic send_plain(input beat_t b);
    send_step(b, 1'b0, no_result);
  endtask

  task automatic wait_drain();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (pending_winners.size() != 0);
  endtask

  task automatic write_floor(input score_t v);
    wait_drain();
    repeat (RESULT_LATENCY + 2) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    floor_val = v;
  endtask

  task automatic add_row(input beat_t b, input bit typed, input int cls, input int score);
    step_t s;
    s.b = b;
    s.typed = typed;
    s.res.cls = cls[CLS_W-1:0];
    s.res.score = score_t'(score);
    plan.insert(plan.size(), s);
  endtask

  task automatic send_noise();
    int r;
    r = $urandom_range(0, 3);
    case (r)
      0: send_plain(mk(CMD_UNUSED, $urandom_range(0, 15), $urandom_range(0, 1023), rand_log(),
                       rand_log(), $urandom_range(0, 1), $urandom_range(0, 1)));
      1: send_plain(mk(CMD_LOAD_TERMS, $urandom_range(NUM_CLASSES, 15), $urandom_range(0, 1023),
                       rand_log(), rand_log(), $urandom_range(0, 1), $urandom_range(0, 1)));
      2: send_plain(mk(CMD_LOAD_TERMS, $urandom_range(0, NUM_CLASSES - 1),
                       $urandom_range(PIXELS, 1023), rand_log(), rand_log(),
                       $urandom_range(0, 1), $urandom_range(0, 1)));
      default: send_plain(mk(CMD_LOAD_PRIOR, $urandom_range(NUM_CLASSES, 15),
                             $urandom_range(0, 1023), rand_log(), rand_log(),
                             $urandom_range(0, 1), $urandom_range(0, 1)));
    endcase
  endtask

  task automatic load_pixel_group(input int pix);
    int order [NUM_CLASSES];
    int j;
    int t;
    for (int i = 0; i < NUM_CLASSES; i++)
      order[i] = i;
    for (int i = NUM_CLASSES - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      t = order[i];
      order[i] = order[j];
      order[j] = t;
    end
    for (int i = 0; i < NUM_CLASSES; i++) begin
      if ($urandom_range(0, 19) == 0)
        send_noise();
      send_plain(mk(CMD_LOAD_TERMS, order[i], pix, rand_log(), rand_log(),
                    $urandom_range(0, 1), $urandom_range(0, 1)));
    end
  endtask

  task automatic send_image();
    int r;
    int n;
    int pix;
    r = $urandom_range(0, 99);
    n = (r < 70) ? $urandom_range(1, 6) : (r < 95) ? $urandom_range(7, 20) :
        $urandom_range(21, 60);
    for (int k = 0; k < n; k++) begin
      r = $urandom_range(0, 39);
      if (r == 0)
        send_plain(mk(CMD_LOAD_PRIOR, $urandom_range(0, NUM_CLASSES - 1), 0, rand_log(),
                      rand_log(), 1'b0, 1'b0));
      else if (r == 1)
        send_plain(mk(CMD_LOAD_TERMS, $urandom_range(0, NUM_CLASSES - 1),
                      $urandom_range(0, PIXELS - 1), rand_log(), rand_log(), 1'b0, 1'b0));
      else if (r == 2)
        send_noise();
      if ($urandom_range(0, 99) < 88)
        pix = ready_pixels[$urandom_range(0, ready_pixels.size() - 1)];
      else
        pix = $urandom_range(PIXELS, 1023);
      send_plain(mk(CMD_CLASSIFY, $urandom_range(0, 15), pix, rand_log(), rand_log(),
                    $urandom_range(0, 1), k == n - 1));
    end
  endtask

  task automatic run_phase(input int quota);
    int start;
    int r;
    start = work_items;
    while (work_items - start < quota) begin
      r = $urandom_range(0, 99);
      if (r < 35)
        load_pixel_group($urandom_range(0, PIXELS - 1));
      else if (r < 80)
        send_image();
      else if (r < 88)
        send_plain(mk(CMD_LOAD_PRIOR, $urandom_range(0, NUM_CLASSES - 1),
                      $urandom_range(0, 1023), rand_log(), rand_log(),
                      $urandom_range(0, 1), $urandom_range(0, 1)));
      else if (r < 96)
        send_noise();
      else
        wait_drain();
    end
  endtask

  always @(posedge clk) begin
    winner_t got;
    winner_t want;
    int      r;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        got.cls = m_tdata[CLS_W-1:0];
        got.score = m_tdata[CLS_W+SCORE_W-1:CLS_W];
        if (pending_winners.size() == 0) begin
          fault_count++;
          if (fault_count <= 10)
            $display("unexpected result beat: class %0d score %0d", got.cls, got.score);
        end else begin
          want = pending_winners.pop_front();
          if (got.cls !== want.cls || got.score !== want.score) begin
            fault_count++;
            if (fault_count <= 10)
              $display("result mismatch: expected class %0d score %0d, got class %0d score %0d",
                       want.cls, want.score, got.cls, got.score);
          end
        end
      end
      if (rx_hold > 0) begin
        rx_hold--;
      end else if (!rx_stalls) begin
        m_tready <= 1'b1;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 55) begin
          m_tready <= 1'b1;
          rx_hold = $urandom_range(0, 7);
        end else if (r < 90) begin
          m_tready <= 1'b0;
          rx_hold = $urandom_range(0, 3);
        end else begin
          m_tready <= 1'b0;
          rx_hold = $urandom_range(10, 80);
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("bernoulli_bayes_pixel_classifier regression: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    score_t floors [NUM_PHASES];
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = '0;
    s_tlast = 1'b0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    floors[0] = FLOOR_RESET;
    floors[1] = 32'sh7fffffff;
    floors[2] = 32'sh80000000;
    floors[3] = '0;
    floors[4] = score_t'(-int'($urandom_range(50000, 250000)));
    floors[5] = FLOOR_RESET;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // All priors and the two corner pixels are loaded before any pixel beat reads them.
    for (int c = 0; c < NUM_CLASSES; c++)
      send_plain(mk(CMD_LOAD_PRIOR, c, 0, '0, '0, 1'b0, 1'b0));
    for (int c = 0; c < NUM_CLASSES; c++) begin
      send_plain(mk(CMD_LOAD_TERMS, c, 0, in_log_t'(-32768), '0, 1'b0, 1'b0));
      send_plain(mk(CMD_LOAD_TERMS, c, PIXELS - 1, in_log_t'(-c * 1024),
                    in_log_t'(-(NUM_CLASSES - 1 - c) * 1024), 1'b1, 1'b1));
    end

    add_row(mk(CMD_CLASSIFY, 0, 0, '0, '0, 1'b1, 1'b1), 1'b1, 0, 0);
    add_row(mk(CMD_CLASSIFY, 0, 0, '0, '0, 1'b0, 1'b1), 1'b1, 0, -32768);
    add_row(mk(CMD_CLASSIFY, 9, PIXELS - 1, '0, '0, 1'b1, 1'b1), 1'b1, 9, 0);
    add_row(mk(CMD_CLASSIFY, 0, PIXELS - 1, '0, '0, 1'b0, 1'b1), 1'b1, 0, 0);
    add_row(mk(CMD_CLASSIFY, 0, 0, '0, '0, 1'b0, 1'b0), 1'b0, 0, 0);
    add_row(mk(CMD_CLASSIFY, 0, PIXELS - 1, '0, '0, 1'b1, 1'b1), 1'b1, 9, -32768);
    add_row(mk(CMD_CLASSIFY, 15, 1023, in_log_t'(-32768), in_log_t'(-32768), 1'b1, 1'b1),
            1'b1, 0, 0);
    add_row(mk(CMD_CLASSIFY, 0, PIXELS, '0, '0, 1'b1, 1'b0), 1'b0, 0, 0);
    add_row(mk(CMD_UNUSED, 15, PIXELS - 1, in_log_t'(-32768), in_log_t'(-32768), 1'b1, 1'b1),
            1'b0, 0, 0);
    add_row(mk(CMD_CLASSIFY, 0, PIXELS - 1, '0, '0, 1'b1, 1'b1), 1'b1, 9, 0);
    add_row(mk(CMD_LOAD_TERMS, NUM_CLASSES, 0, in_log_t'(-32768), in_log_t'(-32768),
               1'b0, 1'b0), 1'b0, 0, 0);
    add_row(mk(CMD_LOAD_TERMS, 15, PIXELS - 1, in_log_t'(-32768), in_log_t'(-32768),
               1'b0, 1'b0), 1'b0, 0, 0);
    add_row(mk(CMD_LOAD_TERMS, 0, PIXELS, in_log_t'(-32768), in_log_t'(-32768), 1'b0, 1'b0),
            1'b0, 0, 0);
    add_row(mk(CMD_LOAD_TERMS, 5, 1023, in_log_t'(-32768), in_log_t'(-32768), 1'b0, 1'b0),
            1'b0, 0, 0);
    add_row(mk(CMD_LOAD_PRIOR, 12, 0, '0, in_log_t'(-32768), 1'b0, 1'b0), 1'b0, 0, 0);
    add_row(mk(CMD_CLASSIFY, 0, 0, '0, '0, 1'b1, 1'b1), 1'b1, 0, 0);
    add_row(mk(CMD_LOAD_PRIOR, 0, 0, '0, in_log_t'(-32768), 1'b0, 1'b0), 1'b0, 0, 0);
    add_row(mk(CMD_CLASSIFY, 0, 0, '0, '0, 1'b1, 1'b1), 1'b1, 1, 0);
    add_row(mk(CMD_LOAD_PRIOR, 0, 0, '0, '0, 1'b0, 1'b0), 1'b0, 0, 0);
    add_row(mk(CMD_CLASSIFY, 0, PIXELS - 1, '0, '0, 1'b0, 1'b0), 1'b0, 0, 0);
    add_row(mk(CMD_CLASSIFY, 0, PIXELS - 1, '0, '0, 1'b1, 1'b1), 1'b1, 0, -9216);
    add_row(mk(CMD_CLASSIFY, 0, 0, '0, '0, 1'b1, 1'b0), 1'b0, 0, 0);
    add_row(mk(CMD_LOAD_PRIOR, 3, 0, '0, in_log_t'(-32768), 1'b0, 1'b0), 1'b0, 0, 0);
    add_row(mk(CMD_CLASSIFY, 0, PIXELS - 1, '0, '0, 1'b1, 1'b1), 1'b1, 9, 0);
    foreach (plan[i])
      send_step(plan[i].b, plan[i].typed, plan[i].res);
    wait_drain();

    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      if (phase > 0)
        write_floor(floors[phase]);
      tx_idle = (phase % 3 != 1);
      rx_stalls = (phase % 3 != 2);
      run_phase(PHASE_ITEMS);
    end
    while (result_count < MIN_RESULTS)
      send_image();

    wait_drain();
    repeat (RESULT_LATENCY + 4) @(posedge clk);
    if (fault_count == 0 && pending_winners.size() == 0)
      $display("bernoulli_bayes_pixel_classifier regression: pass");
    else
      $display("bernoulli_bayes_pixel_classifier regression: fail");
    $finish;
  end

endmodule
`default_nettype wire

### filelist.f
design/bbpc_pkg.sv
design/bbpc_ram.sv
design/bbpc_argmax.sv
design/bernoulli_bayes_pixel_classifier.sv
design/bbpc_checker.sv
tb/testbench.sv
